@@ hdl/msr_pkg.sv @@
// shared constants and types of the two-run merge unit
package msr_pkg;

	localparam int DATA_W          = 32;
	localparam int REG_W           = 6;
	localparam int MAX_SEGMENT_DEF = 32;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;

	localparam logic [REG_W-1:0] SEG_LEN_RST   = 6'd2;
	localparam logic [REG_W-1:0] FIRST_LEN_RST = 6'd1;

	// register index, taken from paddr[2]
	localparam logic REG_SEGMENT_LENGTH   = 1'b0;
	localparam logic REG_FIRST_RUN_LENGTH = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] segment_length;
		logic [REG_W-1:0] first_run_length;
	} cfg_t;

endpackage

@@ hdl/msr_ram.sv @@
// generic single-write, single-read ram with registered read data
module msr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/msr_cfg.sv @@
// apb register file holding segment and first run lengths
module msr_cfg
	import msr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segment_length   <= SEG_LEN_RST;
			cfg_q.first_run_length <= FIRST_LEN_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_SEGMENT_LENGTH:   cfg_q.segment_length   <= pwdata[REG_W-1:0];
				REG_FIRST_RUN_LENGTH: cfg_q.first_run_length <= pwdata[REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SEGMENT_LENGTH:   prdata = APB_DW'(cfg_q.segment_length);
			REG_FIRST_RUN_LENGTH: prdata = APB_DW'(cfg_q.first_run_length);
		endcase
	end

endmodule

@@ hdl/msr_seq.sv @@
// load and merge sequencer driving the two element store copies
module msr_seq
	import msr_pkg::*;
#(
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           in_tvalid,
	output logic                           in_tready,
	input  logic [DATA_W-1:0]              in_tdata,
	output logic                           out_tvalid,
	input  logic                           out_tready,
	output logic [DATA_W-1:0]              out_tdata,
	output logic                           out_tlast,
	output logic                           ram_we,
	output logic [$clog2(MAX_SEGMENT)-1:0] ram_waddr,
	output logic [DATA_W-1:0]              ram_wdata,
	output logic [$clog2(MAX_SEGMENT)-1:0] raddr_left,
	output logic [$clog2(MAX_SEGMENT)-1:0] raddr_right,
	input  logic [DATA_W-1:0]              rdata_left,
	input  logic [DATA_W-1:0]              rdata_right
);

	localparam int AW = $clog2(MAX_SEGMENT);
	localparam int CW = $clog2(MAX_SEGMENT + 1);
	localparam int LW = (CW > REG_W) ? CW : REG_W;

	typedef enum logic [1:0] {ST_LOAD, ST_PRIME, ST_MERGE} state_t;

	state_t           state_q;
	logic [CW-1:0]    load_cnt_q;
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    mid_q;
	logic [CW-1:0]    left_q;
	logic [CW-1:0]    right_q;
	logic [CW-1:0]    emit_cnt_q;
	logic             out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic             out_last_q;

	logic [LW-1:0]    seg_w;
	logic [LW-1:0]    first_w;
	logic [LW-1:0]    len_w;
	logic [LW-1:0]    mid_w;
	logic [CW-1:0]    len_c;
	logic [CW-1:0]    mid_c;
	logic [CW-1:0]    ld_pos;
	logic [CW-1:0]    ld_next;
	logic             in_acc;
	logic             ld_done;
	logic             emit;
	logic             take_right;
	logic             emit_last;
	logic [DATA_W-1:0] pick;
	logic [CW-1:0]    left_d;
	logic [CW-1:0]    right_d;

	// effective lengths: zero segment means one, clip at store depth
	always_comb begin
		seg_w   = LW'(cfg.segment_length);
		first_w = LW'(cfg.first_run_length);
		if (seg_w == '0) begin
			len_w = LW'(1);
		end else if (seg_w > LW'(MAX_SEGMENT)) begin
			len_w = LW'(MAX_SEGMENT);
		end else begin
			len_w = seg_w;
		end
		mid_w = (first_w > len_w) ? len_w : first_w;
		len_c = len_w[CW-1:0];
		mid_c = mid_w[CW-1:0];
	end

	// loading, restarts when the length shrank below the fill
	assign in_tready = (state_q == ST_LOAD);
	assign in_acc    = in_tvalid && in_tready;
	assign ld_pos    = (load_cnt_q >= len_c) ? '0 : load_cnt_q;
	assign ld_next   = ld_pos + CW'(1);
	assign ld_done   = in_acc && (ld_next >= len_c);

	assign ram_we    = in_acc;
	assign ram_waddr = ld_pos[AW-1:0];
	assign ram_wdata = in_tdata;

	// merge choice, ties go to the second run
	always_comb begin
		if (left_q >= mid_q) begin
			take_right = 1'b1;
		end else if (right_q >= len_q) begin
			take_right = 1'b0;
		end else begin
			take_right = !($signed(rdata_left) < $signed(rdata_right));
		end
		pick      = take_right ? rdata_right : rdata_left;
		emit      = (state_q == ST_MERGE) && (!out_valid_q || out_tready);
		emit_last = (emit_cnt_q + CW'(1)) == len_q;
	end

	// read addresses follow the next pointers so read data lines up with the pointer registers
	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		if (ld_done) begin
			left_d  = '0;
			right_d = mid_c;
		end else if (emit) begin
			if (take_right) begin
				right_d = right_q + CW'(1);
			end else begin
				left_d = left_q + CW'(1);
			end
		end
	end

	assign raddr_left  = left_d[AW-1:0];
	assign raddr_right = right_d[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			len_q       <= '0;
			mid_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			left_q  <= left_d;
			right_q <= right_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_value_q <= pick;
				out_last_q  <= emit_last;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						load_cnt_q <= ld_done ? '0 : ld_next;
					end
					if (ld_done) begin
						len_q      <= len_c;
						mid_q      <= mid_c;
						emit_cnt_q <= '0;
						state_q    <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (emit) begin
						emit_cnt_q <= emit_cnt_q + CW'(1);
						if (emit_last) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_value_q;
	assign out_tlast  = out_last_q;

endmodule

@@ hdl/merge_two_sorted_runs_unit.sv @@
// top level of the merge step: merges two ascending runs of one segment
// usage:
//   configure over apb while idle: segment_length at address 0, first_run_length at 4.
//   a segment length of zero acts as one, a length above MAX_SEGMENT clips to it,
//   and a first run longer than the segment leaves the second run empty.
//   in_* stream: one signed 32-bit element per request, one per cycle while loading,
//   in segment order, into two copies of the element store, one per run head.
//   out_* stream: after the last element, the merged ascending sequence comes out
//   one element per request, tlast on the final one; ties emit the second run first.
// timing:
//   after the last element is taken, a prime state reads the run heads once the last
//   write has landed, then the merge state compares them into the output register;
//   results then follow one per cycle while out_tready is high. a segment is loaded,
//   its heads are read, then it is merged; each store copy has a single read port.
//   input is held off (in_tready low) from the last element until the final result
//   has been handed to the output register; a new load may overlap its delivery.
// reset: returns to loading with an empty count and the default lengths; store
//   contents are not cleared, only written entries ever reach the output.
// stalls: out_tready low on a pending result freezes the pointers and output register.
module merge_two_sorted_runs_unit
	import msr_pkg::*;
#(
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// apb configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// element input
	input  logic              in_tvalid,
	output logic              in_tready,
	input  logic [DATA_W-1:0] in_tdata,   // [31:0] in_value
	// merged output
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [DATA_W-1:0] out_tdata,  // [31:0] out_value
	output logic              out_tlast
);

	localparam int AW = $clog2(MAX_SEGMENT);

	cfg_t              cfg;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     raddr_left;
	logic [AW-1:0]     raddr_right;
	logic [DATA_W-1:0] rdata_left;
	logic [DATA_W-1:0] rdata_right;

	msr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msr_seq #(
		.MAX_SEGMENT (MAX_SEGMENT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_tvalid   (in_tvalid),
		.in_tready   (in_tready),
		.in_tdata    (in_tdata),
		.out_tvalid  (out_tvalid),
		.out_tready  (out_tready),
		.out_tdata   (out_tdata),
		.out_tlast   (out_tlast),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.raddr_left  (raddr_left),
		.raddr_right (raddr_right),
		.rdata_left  (rdata_left),
		.rdata_right (rdata_right)
	);

	// store copy read at the first run head
	msr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_SEGMENT)
	) u_ram_left (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr_left),
		.rdata (rdata_left)
	);

	// store copy read at the second run head
	msr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_SEGMENT)
	) u_ram_right (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr_right),
		.rdata (rdata_right)
	);

	// store is written exactly on accepted elements
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we == (in_tvalid && in_tready))
		else $error("store write without matching input request");

	// a pending non-final result means the merge is running, so input is held off
	a_no_load_mid_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && !out_tlast) |-> !in_tready)
		else $error("input taken while merge still in progress");

	// a stalled result keeps its value and flag until it is taken
	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_tvalid && !out_tready) |=>
			(out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
		else $error("result changed while the receiver stalled");

endmodule

@@ verif/merge_two_sorted_runs_unit_tb.sv @@
// self-checking testbench of merge_two_sorted_runs_unit: streams segments, predicts the merge
module merge_two_sorted_runs_unit_tb;
	import msr_pkg::*;

	localparam int MAX_SEG       = MAX_SEGMENT_DEF;
	localparam int IDLE_PCT      = 17;
	localparam int RANDOM_ITEMS  = 410;
	// settle time in drain_results after every owed result has been taken
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_OFF      = 150;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              last;
	} merged_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [APB_AW-1:0] paddr      = '0;
	logic [APB_DW-1:0] pwdata     = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_tvalid  = 1'b0;
	logic              in_tready;
	logic [DATA_W-1:0] in_tdata   = '0;   // [31:0] in_value
	logic              out_tvalid;
	logic              out_tready = 1'b0;
	logic [DATA_W-1:0] out_tdata;         // [31:0] out_value
	logic              out_tlast;

	// predictor state: the loaded elements, the load count and the two length registers
	logic [DATA_W-1:0] seg_store [MAX_SEG];
	int unsigned       seg_loaded;
	logic [REG_W-1:0]  seg_len_cfg;
	logic [REG_W-1:0]  first_len_cfg;

	// merged elements still owed by the block, oldest first
	merged_t           merged_due [$];
	merged_t           head_due;

	int                mismatch_count = 0;
	int unsigned       elements_sent  = 0;
	int unsigned       cycle_count    = 0;
	int                in_idle_pct    = IDLE_PCT;
	int                out_idle_pct   = IDLE_PCT;
	int                hold_cycles    = 0;

	merge_two_sorted_runs_unit #(
		.MAX_SEGMENT(MAX_SEG)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_tvalid (in_tvalid),
		.in_tready (in_tready),
		.in_tdata  (in_tdata),
		.out_tvalid(out_tvalid),
		.out_tready(out_tready),
		.out_tdata (out_tdata),
		.out_tlast (out_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// run guard: a hang anywhere ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("merge_two_sorted_runs_unit test failed");
			$finish;
		end
	end

	// segment length as the block sees it: zero acts as one, long values clip
	function automatic int unsigned effective_length(input logic [REG_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > MAX_SEG)
			return MAX_SEG;
		return n;
	endfunction

	// store one element; on the last of a segment merge both runs into merged_due
	task automatic load_and_merge(input logic [DATA_W-1:0] v);
		int unsigned len, mid, lo, hi;
		logic [DATA_W-1:0] pick;
		len = effective_length(seg_len_cfg);
		// a length shrunk below the count restarts loading at position zero
		if (seg_loaded >= len)
			seg_loaded = 0;
		seg_store[seg_loaded] = v;
		seg_loaded++;
		if (seg_loaded < len)
			return;
		seg_loaded = 0;
		mid = (first_len_cfg > len) ? len : first_len_cfg;
		lo = 0;
		hi = mid;
		for (int k = 0; k < len; k++) begin
			// ties go to the second run
			if (lo >= mid) begin
				pick = seg_store[hi];
				hi++;
			end else if (hi >= len) begin
				pick = seg_store[lo];
				lo++;
			end else if ($signed(seg_store[lo]) < $signed(seg_store[hi])) begin
				pick = seg_store[lo];
				lo++;
			end else begin
				pick = seg_store[hi];
				hi++;
			end
			merged_due.push_back('{value: pick, last: (k == len - 1)});
		end
	endtask

	// mostly wide random values, with extremes and a narrow band for ties
	function automatic int pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(0, 6) - 3;
			default: return $urandom();
		endcase
	endfunction

	// offer one element, with random idle cycles first, until the request is taken
	task automatic send_element(input logic [DATA_W-1:0] v);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_tvalid <= 1'b0;
			in_tdata  <= $urandom();
			@(posedge clk);
		end
		in_tvalid <= 1'b1;
		in_tdata  <= v;
		do @(posedge clk); while (!in_tready);
		elements_sent++;
		load_and_merge(v);
	endtask

	// one segment of len elements; ordered gives two ascending runs split at mid
	task automatic send_segment(input int unsigned len, input int unsigned mid,
		input bit ordered);
		int vals [MAX_SEG];
		int v;
		int unsigned j, run_start;
		for (int unsigned k = 0; k < len; k++) begin
			v = pick_value();
			j = k;
			run_start = (k >= mid) ? mid : 0;
			// insertion keeps each run ascending as it grows
			while (ordered && j > run_start && vals[j - 1] > v) begin
				vals[j] = vals[j - 1];
				j--;
			end
			vals[j] = v;
		end
		for (int unsigned k = 0; k < len; k++)
			send_element(vals[k]);
	endtask

	// stop offering, wait for every owed result, then let the pipeline settle
	task automatic drain_results();
		in_tvalid <= 1'b0;
		while (merged_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write with random upper data bits, then read the register back
	task automatic write_register(input logic idx, input logic [REG_W-1:0] val);
		logic [APB_DW-1:0] wdata;
		wdata = $urandom();
		wdata[REG_W-1:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_SEGMENT_LENGTH)
			seg_len_cfg = val;
		else
			first_len_cfg = val;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(val)) begin
			$display("%0t: register %0d readback expected %h got %h", $time, idx,
				APB_DW'(val), prdata);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_lengths(input int unsigned seg, input int unsigned first);
		drain_results();
		write_register(REG_SEGMENT_LENGTH, REG_W'(seg));
		write_register(REG_FIRST_RUN_LENGTH, REG_W'(first));
	endtask

	// reset lengths: two elements, one per run; extremes swap, equal values tie
	task automatic test_default_lengths();
		send_element(32'h7fff_ffff);
		send_element(32'h8000_0000);
		send_element(32'hffff_ffff);
		send_element(32'hffff_ffff);
		send_element(32'h0000_0001);
		send_element(32'h0000_0000);
	endtask

	// zero segment length acts as one element, with or without a first run
	task automatic test_zero_length();
		set_lengths(0, 0);
		send_element(32'h0000_0000);
		set_lengths(0, 1);
		send_element(32'h7fff_ffff);
	endtask

	// first run longer than the segment, then an empty first run
	task automatic test_first_run_bounds();
		set_lengths(3, 5);
		send_element(-5);
		send_element(0);
		send_element(5);
		set_lengths(3, 0);
		send_element(-2);
		send_element(3);
		send_element(3);
	endtask

	// segment shortened after four of six elements: loading starts over
	task automatic test_length_shrunk();
		set_lengths(6, 3);
		send_element(32'h8000_0000);
		send_element(10);
		send_element(-7);
		send_element(4);
		set_lengths(2, 1);
		send_element(9);
		send_element(-9);
	endtask

	// output held off long enough that the block fills and stalls its input
	task automatic test_output_backpressure();
		set_lengths(8, 4);
		hold_cycles = HOLD_OFF;
		repeat (3) send_segment(8, 4, 1'b1);
	endtask

	// random lengths and contents, mostly two well-formed runs per segment
	task automatic test_random_segments();
		int unsigned stop_at, iter, r, seg, first, eff, cut, remaining;
		stop_at = elements_sent + RANDOM_ITEMS;
		iter = 0;
		while (elements_sent < stop_at) begin
			// a stretch with no idling on either side
			in_idle_pct  = (iter >= 20 && iter < 36) ? 0 : IDLE_PCT;
			out_idle_pct = in_idle_pct;
			if (iter == 0) begin
				set_lengths(63, 63);
			end else if (iter == 1) begin
				set_lengths(32, 31);
			end else if ($urandom_range(0, 99) < 60) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					seg = $urandom_range(1, 8);
				else if (r < 85)
					seg = $urandom_range(9, 20);
				else if (r < 93)
					seg = $urandom_range(21, 32);
				else if (r < 96)
					seg = 0;
				else
					seg = $urandom_range(33, 63);
				eff = effective_length(REG_W'(seg));
				if ($urandom_range(0, 99) < 88)
					first = $urandom_range(0, eff);
				else
					first = $urandom_range(eff + 1, 63);
				set_lengths(seg, first);
			end
			eff = effective_length(seg_len_cfg);
			if (eff >= 3 && $urandom_range(0, 99) < 6) begin
				// partial load, then new lengths, then whatever completes the segment
				cut = $urandom_range(1, eff - 1);
				repeat (cut) send_element(pick_value());
				seg = $urandom_range(1, 40);
				set_lengths(seg, $urandom_range(0, seg));
				eff = effective_length(seg_len_cfg);
				remaining = (seg_loaded >= eff) ? eff : eff - seg_loaded;
				repeat (remaining) send_element(pick_value());
			end else begin
				send_segment(eff, (first_len_cfg > eff) ? eff : first_len_cfg,
					$urandom_range(0, 99) < 85);
			end
			iter++;
		end
	endtask

	// receiver: random stalls, or a counted hold-off when one is asked for
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_tready <= 1'b0;
			end else begin
				out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
			end
		end
	end

	// every accepted result against the oldest owed element
	always @(posedge clk) begin
		if (arst_n && out_tvalid && out_tready) begin
			if (merged_due.size() == 0) begin
				$display("%0t: result with nothing owed: expected none got value %h last %b",
					$time, out_tdata, out_tlast);
				mismatch_count++;
			end else begin
				head_due = merged_due.pop_front();
				if (out_tdata !== head_due.value) begin
					$display("%0t: out_value expected %h got %h", $time, head_due.value,
						out_tdata);
					mismatch_count++;
				end
				if (out_tlast !== head_due.last) begin
					$display("%0t: out_last expected %b got %b", $time, head_due.last,
						out_tlast);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		seg_loaded    = 0;
		seg_len_cfg   = SEG_LEN_RST;
		first_len_cfg = FIRST_LEN_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_lengths();
		test_zero_length();
		test_first_run_bounds();
		test_length_shrunk();
		test_output_backpressure();
		test_random_segments();
		drain_results();
		if (mismatch_count == 0) begin
			$display("merge_two_sorted_runs_unit test passed");
		end else begin
			$display("merge_two_sorted_runs_unit test failed");
		end
		$finish;
	end

endmodule
